// ----- sv/dmq_pkg.sv -----
package dmq_pkg;

  // input item kinds
  typedef enum logic [1:0] {
    KIND_SEND    = 2'd0,
    KIND_DELAYED = 2'd1,
    KIND_PROCESS = 2'd2,
    KIND_CLEAR   = 2'd3
  } kind_t;

  // configuration register indexes
  localparam logic [1:0] REG_QUEUE_LIMIT   = 2'd0;
  localparam logic [1:0] REG_SET_TRIGGER   = 2'd1;
  localparam logic [1:0] REG_CLEAR_TRIGGER = 2'd2;

  localparam logic [4:0] QUEUE_LIMIT_RST   = 5'd16;
  localparam logic [7:0] SET_TRIGGER_RST   = 8'd1;
  localparam logic [7:0] CLEAR_TRIGGER_RST = 8'd2;

  // control state
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH
  } state_t;

  // one queued message
  typedef struct packed {
    logic [31:0] due;
    logic [31:0] second_param;
    logic [31:0] first_param;
    logic [7:0]  target_id;
    logic        has_target;
    logic [7:0]  sender_id;
    logic [7:0]  message_code;
  } entry_t;

  // one delivered message, packed in the order of the output tdata
  typedef struct packed {
    logic [31:0] due_frame;
    logic [31:0] second_param;
    logic [31:0] first_param;
    logic [7:0]  target_id;
    logic [7:0]  sender_id;
    logic [7:0]  message_code;
  } result_t;

  // trigger codes in force
  typedef struct packed {
    logic [7:0] set_code;
    logic [7:0] clear_code;
  } trig_cfg_t;

endpackage

// ----- sv/delayed_message_queue.sv -----
// Frame-scheduled message dispatcher with a pending queue held in a chain of
// QUEUE_DEPTH cells. A send or clear item is handled as it is accepted; a send
// that is due at once puts its result, if it yields one, in the output
// register. A process item is accepted, then the queue rotates through the
// cell chain entry by entry, the head cell feeding the dispatch logic while
// kept entries re-enter at the end of the shrinking window so the remaining
// order is kept; the scan is then left and the held result flushed. Each
// step and the final result wait while the output register is full and not
// taken; the results of one process item come out in queue order with tlast
// on the final one.
module delayed_message_queue #(
  parameter int QUEUE_DEPTH   = 16,
  parameter int TRIGGER_BYTES = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  // configuration
  input  logic         cfg_we,
  input  logic [1:0]   cfg_addr,
  input  logic [7:0]   cfg_wdata,
  // input items
  input  logic         in_tvalid,
  output logic         in_tready,
  // tdata: frame_now[31:0], message_code[39:32], sender_id[47:40],
  // has_target[48], target_id[56:49], first_param[88:57],
  // second_param[120:89], delay_frames[152:121], zero fill
  input  logic [159:0] in_tdata,
  // tuser: kind[1:0]
  input  logic [1:0]   in_tuser,
  // results
  output logic         out_tvalid,
  input  logic         out_tready,
  // tdata: out_message_code[7:0], out_sender_id[15:8], out_target_id[23:16],
  // out_first_param[55:24], out_second_param[87:56], out_due_frame[119:88]
  output logic [119:0] out_tdata,
  output logic         out_tlast
);
  import dmq_pkg::*;

  localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  // configuration registers
  logic [4:0] queue_limit_r;
  trig_cfg_t  trig_cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      queue_limit_r         <= QUEUE_LIMIT_RST;
      trig_cfg_r.set_code   <= SET_TRIGGER_RST;
      trig_cfg_r.clear_code <= CLEAR_TRIGGER_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_QUEUE_LIMIT:   queue_limit_r         <= cfg_wdata[4:0];
        REG_SET_TRIGGER:   trig_cfg_r.set_code   <= cfg_wdata;
        REG_CLEAR_TRIGGER: trig_cfg_r.clear_code <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // input unpacking
  kind_t       kind;
  logic [31:0] now;
  logic [31:0] delay;
  entry_t      in_ent;
  logic [32:0] sum;
  logic [31:0] in_due;

  assign kind  = kind_t'(in_tuser);
  assign now   = in_tdata[31:0];
  assign delay = in_tdata[152:121];

  // due frame with saturation; a targeted send or a negative delay is due now
  always_comb begin
    sum    = {1'b0, now} + ((kind == KIND_SEND) ? 33'd1 : {1'b0, delay});
    in_due = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    if ((kind == KIND_SEND && in_tdata[48]) || (kind != KIND_SEND && delay[31])) begin
      in_due = now;
    end
  end

  always_comb begin
    in_ent.message_code = in_tdata[39:32];
    in_ent.sender_id    = in_tdata[47:40];
    in_ent.has_target   = in_tdata[48];
    in_ent.target_id    = in_tdata[56:49];
    in_ent.first_param  = in_tdata[88:57];
    in_ent.second_param = in_tdata[120:89];
    in_ent.due          = in_due;
  end

  // control registers
  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] steps_r, steps_nxt;
  logic [31:0]      now_r, now_nxt;
  logic             hold_v_r, hold_v_nxt;
  result_t          hold_r, hold_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_last_r, out_last_nxt;
  result_t          out_r, out_nxt;

  // cell chain
  entry_t           cell_ent [QUEUE_DEPTH];
  entry_t           head;
  logic             step;
  logic             keep;
  logic             append;
  logic [IDX_W-1:0] win_last;
  logic [IDX_W-1:0] app_idx;

  assign head     = cell_ent[0];
  assign win_last = IDX_W'(count_r - CNT_W'(1));
  assign app_idx  = IDX_W'(count_r);

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    dmq_cell #(
      .IDX_W (IDX_W),
      .INDEX (i)
    ) u_cell (
      .clk         (clk),
      .step        (step),
      .keep        (keep),
      .win_last    (win_last),
      .append      (append),
      .app_idx     (app_idx),
      .new_entry   (in_ent),
      .head_entry  (head),
      .right_entry ((i == QUEUE_DEPTH - 1) ? head : cell_ent[(i + 1) % QUEUE_DEPTH]),
      .ent         (cell_ent[i])
    );
  end

  // dispatch, fed by the incoming item when idle and by the head cell when scanning
  logic    fire;
  logic    emit;
  result_t res;
  entry_t  disp_ent;

  assign disp_ent = (state_r == ST_SCAN) ? head : in_ent;

  dmq_dispatch #(
    .TRIG_BITS (TRIGGER_BYTES * 8)
  ) u_dispatch (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .cfg   (trig_cfg_r),
    .ent   (disp_ent),
    .emit  (emit),
    .res   (res)
  );

  logic out_free;
  logic accept;
  logic head_due;
  logic room;

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == ST_IDLE) && out_free;
  assign accept    = in_tvalid && in_tready;
  assign head_due  = (head.due <= now_r);
  assign room      = (32'(count_r) < 32'(queue_limit_r)) && (32'(count_r) < QUEUE_DEPTH);

  // next state and datapath control
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    steps_nxt     = steps_r;
    now_nxt       = now_r;
    hold_v_nxt    = hold_v_r;
    hold_nxt      = hold_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_last_nxt  = out_last_r;
    out_nxt       = out_r;
    fire          = 1'b0;
    step          = 1'b0;
    keep          = 1'b0;
    append        = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (kind)
            KIND_SEND, KIND_DELAYED: begin
              if (in_due <= now) begin
                fire = 1'b1;
                if (emit) begin
                  out_valid_nxt = 1'b1;
                  out_last_nxt  = 1'b1;
                  out_nxt       = res;
                end
              end else if (room) begin
                append    = 1'b1;
                count_nxt = count_r + CNT_W'(1);
              end
            end
            KIND_PROCESS: begin
              now_nxt   = now;
              steps_nxt = count_r;
              state_nxt = ST_SCAN;
            end
            KIND_CLEAR: begin
              count_nxt = '0;
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        if (steps_r == '0) begin
          state_nxt = ST_FLUSH;
        end else if (out_free) begin
          step      = 1'b1;
          steps_nxt = steps_r - CNT_W'(1);
          keep      = !head_due;
          if (head_due) begin
            fire      = 1'b1;
            count_nxt = count_r - CNT_W'(1);
            if (emit) begin
              // previous result goes out, this one waits to learn if it is last
              if (hold_v_r) begin
                out_valid_nxt = 1'b1;
                out_last_nxt  = 1'b0;
                out_nxt       = hold_r;
              end
              hold_v_nxt = 1'b1;
              hold_nxt   = res;
            end
          end
        end
      end
      ST_FLUSH: begin
        if (!hold_v_r) begin
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          out_valid_nxt = 1'b1;
          out_last_nxt  = 1'b1;
          out_nxt       = hold_r;
          hold_v_nxt    = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      steps_r     <= '0;
      hold_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      steps_r     <= steps_nxt;
      hold_v_r    <= hold_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    now_r      <= now_nxt;
    hold_r     <= hold_nxt;
    out_r      <= out_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_r;
  assign out_tlast  = out_last_r;

endmodule

// ----- sv/dmq_cell.sv -----
module dmq_cell #(
  parameter int IDX_W = 4,
  parameter int INDEX = 0
) (
  input  logic            clk,
  input  logic            step,
  input  logic            keep,
  input  logic [IDX_W-1:0] win_last,
  input  logic            append,
  input  logic [IDX_W-1:0] app_idx,
  input  dmq_pkg::entry_t new_entry,
  input  dmq_pkg::entry_t head_entry,
  input  dmq_pkg::entry_t right_entry,
  output dmq_pkg::entry_t ent
);
  import dmq_pkg::*;

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

  entry_t ent_r;

  // append a new entry, or rotate the scan window one place toward the head
  always_ff @(posedge clk) begin
    if (append && app_idx == MY_IDX) begin
      ent_r <= new_entry;
    end else if (step) begin
      if (keep && win_last == MY_IDX) begin
        ent_r <= head_entry;
      end else begin
        ent_r <= right_entry;
      end
    end
  end

  assign ent = ent_r;

endmodule

// ----- sv/dmq_dispatch.sv -----
module dmq_dispatch #(
  parameter int TRIG_BITS = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               fire,
  input  dmq_pkg::trig_cfg_t cfg,
  input  dmq_pkg::entry_t    ent,
  output logic               emit,
  output dmq_pkg::result_t   res
);
  import dmq_pkg::*;

  localparam int TB_W = (TRIG_BITS > 1) ? $clog2(TRIG_BITS) : 1;

  logic [TRIG_BITS-1:0] trig_r;
  logic [TRIG_BITS-1:0] trig_nxt;
  logic                 is_set;
  logic                 is_clr;
  logic                 idx_ok;
  logic [TB_W-1:0]      idx;

  // trigger code decode, set wins over clear
  assign is_set = (ent.message_code == cfg.set_code);
  assign is_clr = (ent.message_code == cfg.clear_code);
  assign idx_ok = !ent.first_param[31] && (ent.first_param < 32'(TRIG_BITS));
  assign idx    = ent.first_param[TB_W-1:0];

  // bitmap update
  always_comb begin
    trig_nxt = trig_r;
    if (fire && idx_ok) begin
      if (is_set) begin
        trig_nxt[idx] = 1'b1;
      end else if (is_clr) begin
        trig_nxt[idx] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trig_r <= '0;
    end else begin
      trig_r <= trig_nxt;
    end
  end

  // plain message with a target becomes a result
  assign emit = !is_set && !is_clr && ent.has_target;

  always_comb begin
    res.message_code = ent.message_code;
    res.sender_id    = ent.sender_id;
    res.target_id    = ent.target_id;
    res.first_param  = ent.first_param;
    res.second_param = ent.second_param;
    res.due_frame    = ent.due;
  end

endmodule
